FILE: hw/rtl/sida_pkg.sv
// Shared types and constants for the signed integer to decimal text unit.
`timescale 1ns / 1ps

package sida_pkg;

   localparam int MAG_W       = 64;
   localparam int NUM_DIGITS  = 20;
   localparam int DIGIT_W     = 4;
   localparam int CHAR_W      = 6;
   localparam int COUNT_W     = 5;
   localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
   localparam int BITS_PER_CYC = 2;
   localparam int ITER_LAST   = MAG_W / BITS_PER_CYC - 1;
   localparam int ITER_W      = $clog2(MAG_W / BITS_PER_CYC);

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
   localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

   typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_type;

   // One classified word on its way from the front to the converter.
   typedef struct packed {
      logic             negative;
      logic [MAG_W-1:0] magnitude;
   } item_type;

endpackage

FILE: hw/rtl/sida_front.sv
// Input stage: takes a number, splits off the sign and forms the magnitude.
`timescale 1ns / 1ps

module sida_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic signed [63:0]       req_number,
   output logic                     req_stall,
   output logic                     item_valid,
   output sida_pkg::item_type       item,
   input  logic                     item_stall
);
   import sida_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;
   logic [MAG_W-1:0] raw;

   assign raw       = MAG_W'(req_number);
   assign req_stall = valid_ff && item_stall;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = take || (valid_ff && item_stall);
      item_in  = item_ff;
      if (take) begin
         item_in.negative  = raw[MAG_W-1];
         // two's complement negate; the most negative value lands on 2^63
         item_in.magnitude = raw[MAG_W-1] ? (~raw + MAG_W'(1)) : raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: hw/rtl/sida_queue.sv
// Two-entry queue between the input stage and the converter.
`timescale 1ns / 1ps

module sida_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  sida_pkg::item_type in_item,
   output logic               in_stall,
   output logic               out_valid,
   output sida_pkg::item_type out_item,
   input  logic               out_stall
);
   import sida_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;

   assign in_stall  = (fill_ff == 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

FILE: hw/rtl/sida_back.sv
// Converter: shift-and-add-3 binary to BCD, then one character per cycle out while the output is not stalled.
`timescale 1ns / 1ps

module sida_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              item_valid,
   input  sida_pkg::item_type                item,
   output logic                              item_stall,
   output logic                              rsp_valid,
   output logic [sida_pkg::CHAR_W-1:0]       rsp_text_char,
   output logic                              rsp_is_final,
   output logic [sida_pkg::COUNT_W-1:0]      rsp_char_count,
   input  logic                              rsp_stall
);
   import sida_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_FIND,
      ST_SIGN,
      ST_DIGS
   } state_type;

   state_type              state_ff, state_in;
   logic                   neg_ff, neg_in;
   logic [MAG_W-1:0]       bin_ff, bin_in;
   digits_type             bcd_ff, bcd_in;
   logic [ITER_W-1:0]      iter_ff, iter_in;
   logic [DIGIT_IDX_W-1:0] idx_ff, idx_in;
   logic [COUNT_W-1:0]     cnt_ff, cnt_in;
   logic                   out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]      out_char_ff, out_char_in;
   logic                   out_final_ff, out_final_in;
   logic [COUNT_W-1:0]     out_count_ff, out_count_in;
   logic [DIGIT_IDX_W-1:0] lead;
   logic                   load_ok;
   logic                   last_digit;

   // one double-dabble step: add 3 to digits of 5 or more, then shift in a bit
   function automatic digits_type dd_step(input digits_type d, input logic b);
      digits_type                    a;
      logic [NUM_DIGITS*DIGIT_W-1:0] v;
      a = d;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (a[i] inside {[4'd5:4'd15]}) begin
            a[i] = a[i] + DIGIT_W'(3);
         end
      end
      v = a;
      v = {v[NUM_DIGITS*DIGIT_W-2:0], b};
      return v;
   endfunction

   // most significant non-zero digit; zero keeps the units digit
   always_comb begin
      lead = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i] != '0) begin
            lead = DIGIT_IDX_W'(i);
         end
      end
   end

   assign item_stall = (state_ff != ST_IDLE);
   assign load_ok    = !out_valid_ff || !rsp_stall;
   assign last_digit = (idx_ff == '0);

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      iter_in      = iter_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_char_in  = out_char_ff;
      out_final_in = out_final_ff;
      out_count_in = out_count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               neg_in   = item.negative;
               bin_in   = item.magnitude;
               bcd_in   = '0;
               iter_in  = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in  = dd_step(dd_step(bcd_ff, bin_ff[MAG_W-1]), bin_ff[MAG_W-2]);
            bin_in  = bin_ff << BITS_PER_CYC;
            iter_in = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(ITER_LAST)) begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            idx_in   = lead;
            cnt_in   = '0;
            state_in = neg_ff ? ST_SIGN : ST_DIGS;
         end
         ST_SIGN: begin
            if (load_ok) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_MINUS;
               out_final_in = 1'b0;
               out_count_in = '0;
               cnt_in       = COUNT_W'(1);
               state_in     = ST_DIGS;
            end
         end
         ST_DIGS: begin
            if (load_ok) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_ZERO + CHAR_W'(bcd_ff[idx_ff]);
               out_final_in = last_digit;
               out_count_in = last_digit ? (cnt_ff + COUNT_W'(1)) : '0;
               cnt_in       = cnt_ff + COUNT_W'(1);
               idx_in       = idx_ff - DIGIT_IDX_W'(1);
               if (last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      neg_ff       <= neg_in;
      bin_ff       <= bin_in;
      bcd_ff       <= bcd_in;
      iter_ff      <= iter_in;
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      out_char_ff  <= out_char_in;
      out_final_ff <= out_final_in;
      out_count_ff <= out_count_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_text_char  = out_char_ff;
   assign rsp_is_final   = out_final_ff;
   assign rsp_char_count = out_count_ff;

endmodule

FILE: hw/rtl/signed_int_to_decimal_ascii_unit.sv
// Top level: signed 64-bit integer to decimal ASCII text, one character per word.
//
//   channel | ports                                         | direction
//   --------+-----------------------------------------------+----------
//   req     | req_valid, req_stall, req_number              | in
//   rsp     | rsp_valid, rsp_stall, rsp_text_char,          | out
//           | rsp_is_final, rsp_char_count                  |
//
// A number passes from the queue through the double-dabble loop (two bits a cycle
// over 64 bits), then a search for the leading digit, and then its characters,
// the sign first for a negative number, go out in order.
// The input stage and two-entry queue keep taking up to three numbers while the
// converter is busy or its output word is stalled.
// Reset is synchronous and active high; it empties the queue and idles the
// converter. No clearing pass is needed.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [63:0]           req_number,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [sida_pkg::CHAR_W-1:0]  rsp_text_char,
   output logic                         rsp_is_final,
   output logic [sida_pkg::COUNT_W-1:0] rsp_char_count
);
   import sida_pkg::*;

   // front -> queue
   logic     fr_valid;
   item_type fr_item;
   logic     fr_stall;
   // queue -> converter
   logic     bk_valid;
   item_type bk_item;
   logic     bk_stall;

   // sign split and negate
   sida_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_number (req_number),
      .req_stall  (req_stall),
      .item_valid (fr_valid),
      .item       (fr_item),
      .item_stall (fr_stall)
   );

   // lets the front keep taking words while the converter works
   sida_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_item   (fr_item),
      .in_stall  (fr_stall),
      .out_valid (bk_valid),
      .out_item  (bk_item),
      .out_stall (bk_stall)
   );

   // BCD conversion, leading-zero skip and character emission
   sida_back u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (bk_valid),
      .item           (bk_item),
      .item_stall     (bk_stall),
      .rsp_valid      (rsp_valid),
      .rsp_text_char  (rsp_text_char),
      .rsp_is_final   (rsp_is_final),
      .rsp_char_count (rsp_char_count),
      .rsp_stall      (rsp_stall)
   );

endmodule

FILE: hw/rtl/sida_checker.sv
// Port-level checks for the decimal text unit, bound to the top level.
`timescale 1ns / 1ps

module sida_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [63:0] req_number,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [5:0]  rsp_text_char,
   input logic        rsp_is_final,
   input logic [4:0]  rsp_char_count
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_number))
      else $error("req word changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_text_char)
         && $stable(rsp_is_final) && $stable(rsp_char_count))
      else $error("rsp word changed while stalled");

   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_text_char == 6'd45)
         || (rsp_text_char >= 6'd48 && rsp_text_char <= 6'd57))
      else $error("rsp character outside minus and digits");

   a_count_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_final |-> rsp_char_count == 5'd0)
      else $error("char count set on a non-final character");

   a_final_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_final |-> rsp_text_char != 6'd45
         && rsp_char_count >= 5'd1 && rsp_char_count <= 5'd20)
      else $error("final character malformed");

endmodule

bind signed_int_to_decimal_ascii_unit sida_checker u_sida_checker (.*);
